### src/peripheral_power_and_register_guard_top_assert.svh
// Assertion macros for the peripheral power and register guard.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is high.
`ifndef PERIPHERAL_POWER_AND_REGISTER_GUARD_TOP_ASSERT_SVH
`define PERIPHERAL_POWER_AND_REGISTER_GUARD_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/prg_pkg.sv
// Shared types and constants of the peripheral power and register guard.
// Used by peripheral_power_and_register_guard_top; depends on nothing.
package prg_pkg;

   // Number of ticks spent in the starting state before the block is ready.
   localparam logic [7:0] STARTUP_TICKS = 8'd3;

   // Register bank geometry and reload values.
   localparam int unsigned BANK_DEPTH = 4;
   localparam logic [7:0] BANK0_RELOAD = 8'h42;
   localparam logic [7:0] WRITABLE_ADDR = 8'd1;
   localparam logic [1:0] MODE_REFUSED = 2'd3;

   typedef enum logic [1:0] {
      PWR_OFF      = 2'd0,
      PWR_STARTING = 2'd1,
      PWR_READY    = 2'd2
   } power_mode_type;

   typedef enum logic [2:0] {
      REQ_ENABLE  = 3'd0,
      REQ_DISABLE = 3'd1,
      REQ_TICK    = 3'd2,
      REQ_READ    = 3'd3,
      REQ_WRITE   = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_READY = 3'd1,
      ST_RANGE     = 3'd2,
      ST_READ_ONLY = 3'd3,
      ST_MODE3     = 3'd4
   } status_type;

   // One request as it arrives on the request channel.
   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] address;
      logic [7:0] write_data;
   } guard_req_type;

   // One response as it leaves on the response channel.
   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] status;
      logic [1:0] power_state;
   } guard_rsp_type;

endpackage

### src/peripheral_power_and_register_guard_top.sv
// A request accepted at a clock edge has its response registered and valid right after that edge.
// One request per cycle unless a stalled response blocks it; the power state, tick count and
// register bank update in the accepting cycle, and the response register frees itself when taken.
// Reset (synchronous, active high): power off, tick count zero, registers 0x42, 0, 0, 0,
// and no response pending. Depends on prg_pkg and the assertion macro header.
module peripheral_power_and_register_guard_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  prg_pkg::guard_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output prg_pkg::guard_rsp_type rsp_payload
);
   import prg_pkg::*;

   power_mode_type power_mode_ff, power_mode_in;
   logic [7:0]     startup_count_ff, startup_count_in;
   logic [7:0]     reg_bank_ff [BANK_DEPTH];
   logic [7:0]     reg_bank_in [BANK_DEPTH];
   logic           rsp_valid_ff, rsp_valid_in;
   guard_rsp_type  rsp_data_ff, rsp_data_in;
   logic           accept;
   logic           addr_in_range;
   logic [1:0]     bank_index;
   logic [7:0]     read_byte;
   status_type     status_code;

   // A request is taken whenever no response is stuck in the output register.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign addr_in_range = (req_payload.address < 8'(BANK_DEPTH));
   assign bank_index    = req_payload.address[1:0];

   // Evaluate the request against the current state.
   always_comb begin
      power_mode_in    = power_mode_ff;
      startup_count_in = startup_count_ff;
      reg_bank_in      = reg_bank_ff;
      read_byte        = 8'd0;
      status_code      = ST_OK;
      unique case (req_payload.req_type)
         REQ_ENABLE: begin
            if (power_mode_ff == PWR_OFF) begin
               power_mode_in    = PWR_STARTING;
               startup_count_in = 8'd0;
               reg_bank_in[0]   = BANK0_RELOAD;
               reg_bank_in[1]   = 8'd0;
               reg_bank_in[2]   = 8'd0;
               reg_bank_in[3]   = 8'd0;
            end
         end
         REQ_DISABLE: begin
            power_mode_in    = PWR_OFF;
            startup_count_in = 8'd0;
         end
         REQ_TICK: begin
            if (power_mode_ff == PWR_STARTING && startup_count_ff < STARTUP_TICKS) begin
               startup_count_in = startup_count_ff + 8'd1;
               if (startup_count_ff + 8'd1 == STARTUP_TICKS) begin
                  power_mode_in = PWR_READY;
               end
            end
         end
         REQ_READ: begin
            priority if (power_mode_ff != PWR_READY) begin
               status_code = ST_NOT_READY;
            end else if (!addr_in_range) begin
               status_code = ST_RANGE;
            end else begin
               read_byte = reg_bank_ff[bank_index];
            end
         end
         REQ_WRITE: begin
            priority if (power_mode_ff != PWR_READY) begin
               status_code = ST_NOT_READY;
            end else if (!addr_in_range) begin
               status_code = ST_RANGE;
            end else if (req_payload.address != WRITABLE_ADDR) begin
               status_code = ST_READ_ONLY;
            end else if (req_payload.write_data[3:2] == MODE_REFUSED) begin
               status_code = ST_MODE3;
            end else begin
               reg_bank_in[1] = req_payload.write_data;
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.read_data   = read_byte;
      rsp_data_in.status      = status_code;
      rsp_data_in.power_state = power_mode_in;
   end

   // The output register holds while stalled and empties once taken.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Peripheral state, updated only by accepted requests.
   always_ff @(posedge clock) begin
      if (reset) begin
         power_mode_ff    <= PWR_OFF;
         startup_count_ff <= 8'd0;
         reg_bank_ff[0]   <= BANK0_RELOAD;
         reg_bank_ff[1]   <= 8'd0;
         reg_bank_ff[2]   <= 8'd0;
         reg_bank_ff[3]   <= 8'd0;
      end else if (accept) begin
         power_mode_ff    <= power_mode_in;
         startup_count_ff <= startup_count_in;
         reg_bank_ff      <= reg_bank_in;
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload is loaded with each accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`include "peripheral_power_and_register_guard_top_assert.svh"

   // The tick count never runs past the startup target.
   `PRG_ASSERT_SAME(a_count_bounded, clock, reset, 1'b1,
                    startup_count_ff <= STARTUP_TICKS, "startup count exceeded target")
   // Ready is only reached with a full tick count.
   `PRG_ASSERT_SAME(a_ready_count, clock, reset, power_mode_ff == PWR_READY,
                    startup_count_ff == STARTUP_TICKS, "ready without full tick count")
   // A refused access never returns data.
   `PRG_ASSERT_SAME(a_refused_zero, clock, reset,
                    rsp_valid_ff && rsp_data_ff.status != ST_OK,
                    rsp_data_ff.read_data == 8'd0, "refused access returned data")
   // An accepted disable leaves the block powered off.
   `PRG_ASSERT_NEXT(a_disable_off, clock, reset,
                    accept && req_payload.req_type == REQ_DISABLE,
                    power_mode_ff == PWR_OFF && rsp_data_ff.power_state == PWR_OFF,
                    "disable did not power off")

endmodule

### tb/tb_top.sv
// Self-checking testbench for peripheral_power_and_register_guard_top.
// Depends on prg_pkg; it predicts each response and compares it with the response channel.
// Directed checks come first, then random traffic under several idle and stall patterns.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import prg_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   guard_req_type req_payload = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   guard_rsp_type rsp_payload;

   // Predicted state of the guard.
   power_mode_type guard_power = PWR_OFF;
   logic [7:0]     guard_ticks = '0;
   logic [7:0]     guard_bank [BANK_DEPTH];

   // Responses still owed by the block, oldest first.
   guard_rsp_type owed_responses [$];

   int error_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   peripheral_power_and_register_guard_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Restore the power-up contents of the register bank.
   function automatic void reload_bank();
      guard_bank[0] = BANK0_RELOAD;
      for (int i = 1; i < BANK_DEPTH; i++) begin
         guard_bank[i] = '0;
      end
   endfunction

   // Apply one request to the predicted state and return the response it should produce.
   function automatic guard_rsp_type apply_request(guard_req_type r);
      guard_rsp_type rsp;
      rsp.read_data = '0;
      rsp.status = ST_OK;
      case (r.req_type)
         REQ_ENABLE: begin
            if (guard_power == PWR_OFF) begin
               guard_power = PWR_STARTING;
               guard_ticks = '0;
               reload_bank();
            end
         end
         REQ_DISABLE: begin
            guard_power = PWR_OFF;
            guard_ticks = '0;
         end
         REQ_TICK: begin
            if (guard_power == PWR_STARTING && guard_ticks < STARTUP_TICKS) begin
               guard_ticks = guard_ticks + 8'd1;
               if (guard_ticks == STARTUP_TICKS) begin
                  guard_power = PWR_READY;
               end
            end
         end
         REQ_READ: begin
            if (guard_power != PWR_READY) begin
               rsp.status = ST_NOT_READY;
            end else if (r.address >= BANK_DEPTH) begin
               rsp.status = ST_RANGE;
            end else begin
               rsp.read_data = guard_bank[r.address[1:0]];
            end
         end
         REQ_WRITE: begin
            if (guard_power != PWR_READY) begin
               rsp.status = ST_NOT_READY;
            end else if (r.address >= BANK_DEPTH) begin
               rsp.status = ST_RANGE;
            end else if (r.address != WRITABLE_ADDR) begin
               rsp.status = ST_READ_ONLY;
            end else if (r.write_data[3:2] == MODE_REFUSED) begin
               rsp.status = ST_MODE3;
            end else begin
               guard_bank[WRITABLE_ADDR[1:0]] = r.write_data;
            end
         end
         default: begin
            // Unknown request codes leave everything alone.
         end
      endcase
      rsp.power_state = guard_power;
      return rsp;
   endfunction

   // Print one mismatch line (the first hundred only) and count it.
   task automatic report_mismatch(input string what);
      if (error_count < 100) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   // Compare one accepted response with the oldest owed one.
   task automatic check_response(input guard_rsp_type got);
      guard_rsp_type want;
      if (owed_responses.size() == 0) begin
         report_mismatch($sformatf("response with none owed: %h", got));
      end else begin
         want = owed_responses.pop_front();
         if (got.read_data !== want.read_data) begin
            report_mismatch($sformatf("read_data %h, predicted %h", got.read_data,
                                      want.read_data));
         end
         if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
         end
         if (got.power_state !== want.power_state) begin
            report_mismatch($sformatf("power_state %0d, predicted %0d", got.power_state,
                                      want.power_state));
         end
      end
   endtask

   // Response side: check each accepted response and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_response(rsp_payload);
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Send one request, with random idle cycles ahead of it, and predict its response.
   task automatic send_request(input guard_req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do begin
         @(posedge clock);
      end while (req_stall);
      owed_responses.push_back(apply_request(item));
   endtask

   task automatic send_fields(input logic [2:0] code, input logic [7:0] addr,
                              input logic [7:0] data);
      guard_req_type item;
      item.req_type = code;
      item.address = addr;
      item.write_data = data;
      send_request(item);
   endtask

   // Hold the request channel idle until every owed response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_responses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Everything is refused or ignored while the power is off.
   task automatic test_powered_off();
      send_fields(REQ_READ, 8'd0, 8'd0);
      send_fields(REQ_WRITE, 8'd1, 8'h11);
      send_fields(REQ_TICK, 8'd0, 8'd0);
      send_fields(3'd5, 8'hFF, 8'hFF);
      send_fields(3'd7, 8'h00, 8'h00);
      send_fields(REQ_DISABLE, 8'd0, 8'd0);
   endtask

   // Enable, a second enable with no effect, the startup ticks and a spare tick.
   task automatic test_power_up();
      send_fields(REQ_ENABLE, 8'd0, 8'd0);
      send_fields(REQ_ENABLE, 8'd0, 8'd0);
      repeat (STARTUP_TICKS + 1) send_fields(REQ_TICK, 8'd0, 8'd0);
   endtask

   // Reads of registers 0 and 3 and of out-of-range addresses.
   task automatic test_reads();
      send_fields(REQ_READ, 8'd0, 8'hFF);
      send_fields(REQ_READ, 8'd3, 8'd0);
      send_fields(REQ_READ, 8'd4, 8'd0);
      send_fields(REQ_READ, 8'd255, 8'd0);
   endtask

   // Writes through the mode, read-only and range refusal checks and one accepted write read back.
   task automatic test_writes();
      send_fields(REQ_WRITE, 8'd1, 8'hFF);
      send_fields(REQ_WRITE, 8'd1, 8'hF3);
      send_fields(REQ_READ, 8'd1, 8'd0);
      send_fields(REQ_WRITE, 8'd0, 8'h00);
      send_fields(REQ_WRITE, 8'd3, 8'h01);
      send_fields(REQ_WRITE, 8'd200, 8'h0C);
   endtask

   // Disable keeps the bank, but access is refused until the next startup.
   task automatic test_disable();
      send_fields(REQ_DISABLE, 8'd0, 8'd0);
      send_fields(REQ_READ, 8'd1, 8'd0);
      send_fields(REQ_ENABLE, 8'd0, 8'd0);
   endtask

   // Pick a request that mostly follows the power-up sequence, with some noise.
   function automatic guard_req_type pick_request();
      guard_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.address = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 3));
      r.write_data = 8'($urandom_range(0, 255));
      if (pick < 3) begin
         r.req_type = 3'($urandom_range(0, 7));
      end else if (pick < 6) begin
         r.req_type = REQ_DISABLE;
      end else if (guard_power == PWR_OFF) begin
         r.req_type = (pick < 85) ? REQ_ENABLE : 3'($urandom_range(REQ_TICK, REQ_WRITE));
      end else if (guard_power == PWR_STARTING) begin
         r.req_type = (pick < 80) ? REQ_TICK : 3'($urandom_range(REQ_ENABLE, REQ_WRITE));
      end else if (pick < 50) begin
         r.req_type = REQ_READ;
      end else if (pick < 92) begin
         r.req_type = REQ_WRITE;
         // Aim most writes at the one writable register.
         if (pick < 80) r.address = WRITABLE_ADDR;
      end else begin
         r.req_type = 3'($urandom_range(REQ_ENABLE, REQ_TICK));
      end
      return r;
   endfunction

   // Random traffic with the given idle and stall rates; ignored codes do not count.
   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      guard_req_type item;
      int sent;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < count) begin
         item = pick_request();
         send_request(item);
         if (item.req_type <= REQ_WRITE) sent++;
         // Once in the middle, let every owed response come back first.
         if (sent == count / 2 && item.req_type <= REQ_WRITE) drain_responses();
      end
      drain_responses();
   endtask

   // Stop a hung run.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Test sequence.
   initial begin
      reload_bank();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_powered_off();
      test_power_up();
      test_reads();
      test_writes();
      test_disable();
      drain_responses();
      test_random_traffic(450, 0, 0);
      test_random_traffic(450, 76, 0);
      test_random_traffic(450, 0, 76);
      test_random_traffic(450, 19, 19);
      rsp_stall_pct = 0;
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/prg_pkg.sv
src/peripheral_power_and_register_guard_top.sv
tb/tb_top.sv
